// File: src/xibe_pkg.sv
// ----------------------------------------------------------------------------
// xibe_pkg
// Shared types, form codes and the form decode table for the x86-64
// instruction byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xibe_pkg;

    localparam int XIBE_MAX_BYTES   = 10;
    localparam int XIBE_VEC_W       = 8 * XIBE_MAX_BYTES;
    localparam int XIBE_CNT_W       = 4;
    localparam int XIBE_QUEUE_DEPTH = 2;

    typedef enum logic [4:0] {
        FORM_MOV_R32_IMM32 = 5'd0,
        FORM_MOV_R64_IMM64 = 5'd1,
        FORM_MOVZX_R32_M8  = 5'd2,
        FORM_MOV_R8_M8     = 5'd3,
        FORM_MOV_R16_M16   = 5'd4,
        FORM_MOV_R32_M32   = 5'd5,
        FORM_MOV_M8_R8     = 5'd6,
        FORM_MOV_M16_R16   = 5'd7,
        FORM_MOV_M32_R32   = 5'd8,
        FORM_RET           = 5'd9,
        FORM_ADD_M8_R8     = 5'd10,
        FORM_ADD_M16_R16   = 5'd11,
        FORM_ADD_M32_R32   = 5'd12,
        FORM_INC_M32       = 5'd13,
        FORM_DEC_M32       = 5'd14,
        FORM_CMP_R8_M8     = 5'd15,
        FORM_OR_M8_R8      = 5'd16,
        FORM_AND_M8_R8     = 5'd17,
        FORM_XOR_M8_R8     = 5'd18,
        FORM_JZ_REL8       = 5'd19,
        FORM_JNZ_REL8      = 5'd20,
        FORM_SETC_M8       = 5'd21,
        FORM_SETNC_M8      = 5'd22,
        FORM_SUB_M8_R8     = 5'd23,
        FORM_SHR_M8        = 5'd24,
        FORM_SHL_M8        = 5'd25,
        FORM_SUB_R8_M8     = 5'd26,
        FORM_SUB_R8_R8     = 5'd27
    } form_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_MEM,
        KIND_RR,
        KIND_MOVI32,
        KIND_MOVI64,
        KIND_RET,
        KIND_JCC
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       p66;
        logic       esc;
        logic [7:0] op;
        logic       fix_en;
        logic [2:0] fix_reg;
    } form_info_t;

    // one encoded instruction: bytes in order from the low end, plus count
    typedef struct packed {
        logic [XIBE_VEC_W-1:0] bytes;
        logic [XIBE_CNT_W-1:0] count;
    } xibe_item_t;

    function automatic form_info_t xibe_mem(input logic p66, input logic esc,
                                            input logic [7:0] op);
        form_info_t f;
        f.kind    = KIND_MEM;
        f.p66     = p66;
        f.esc     = esc;
        f.op      = op;
        f.fix_en  = 1'b0;
        f.fix_reg = 3'd0;
        return f;
    endfunction

    function automatic form_info_t xibe_mem_fix(input logic esc, input logic [7:0] op,
                                                input logic [2:0] fix);
        form_info_t f;
        f         = xibe_mem(1'b0, esc, op);
        f.fix_en  = 1'b1;
        f.fix_reg = fix;
        return f;
    endfunction

    function automatic form_info_t xibe_decode(input logic [4:0] code);
        form_info_t f;
        f = xibe_mem(1'b0, 1'b0, 8'h00);
        f.kind = KIND_NONE;
        unique case (form_t'(code))
            FORM_MOV_R32_IMM32: begin f.kind = KIND_MOVI32; f.op = 8'hB8; end
            FORM_MOV_R64_IMM64: begin f.kind = KIND_MOVI64; f.op = 8'hB8; end
            FORM_MOVZX_R32_M8:  f = xibe_mem(1'b0, 1'b1, 8'hB6);
            FORM_MOV_R8_M8:     f = xibe_mem(1'b0, 1'b0, 8'h8A);
            FORM_MOV_R16_M16:   f = xibe_mem(1'b1, 1'b0, 8'h8B);
            FORM_MOV_R32_M32:   f = xibe_mem(1'b0, 1'b0, 8'h8B);
            FORM_MOV_M8_R8:     f = xibe_mem(1'b0, 1'b0, 8'h88);
            FORM_MOV_M16_R16:   f = xibe_mem(1'b1, 1'b0, 8'h89);
            FORM_MOV_M32_R32:   f = xibe_mem(1'b0, 1'b0, 8'h89);
            FORM_RET:           begin f.kind = KIND_RET; f.op = 8'hC3; end
            FORM_ADD_M8_R8:     f = xibe_mem(1'b0, 1'b0, 8'h00);
            FORM_ADD_M16_R16:   f = xibe_mem(1'b1, 1'b0, 8'h01);
            FORM_ADD_M32_R32:   f = xibe_mem(1'b0, 1'b0, 8'h01);
            FORM_INC_M32:       f = xibe_mem_fix(1'b0, 8'hFF, 3'd0);
            FORM_DEC_M32:       f = xibe_mem_fix(1'b0, 8'hFF, 3'd1);
            FORM_CMP_R8_M8:     f = xibe_mem(1'b0, 1'b0, 8'h3A);
            FORM_OR_M8_R8:      f = xibe_mem(1'b0, 1'b0, 8'h08);
            FORM_AND_M8_R8:     f = xibe_mem(1'b0, 1'b0, 8'h20);
            FORM_XOR_M8_R8:     f = xibe_mem(1'b0, 1'b0, 8'h30);
            FORM_JZ_REL8:       begin f.kind = KIND_JCC; f.op = 8'h74; end
            FORM_JNZ_REL8:      begin f.kind = KIND_JCC; f.op = 8'h75; end
            FORM_SETC_M8:       f = xibe_mem_fix(1'b1, 8'h92, 3'd0);
            FORM_SETNC_M8:      f = xibe_mem_fix(1'b1, 8'h93, 3'd0);
            FORM_SUB_M8_R8:     f = xibe_mem(1'b0, 1'b0, 8'h28);
            FORM_SHR_M8:        f = xibe_mem_fix(1'b0, 8'hD0, 3'd5);
            FORM_SHL_M8:        f = xibe_mem_fix(1'b0, 8'hD0, 3'd4);
            FORM_SUB_R8_M8:     f = xibe_mem(1'b0, 1'b0, 8'h2A);
            FORM_SUB_R8_R8:     begin f.kind = KIND_RR; f.op = 8'h28; end
            default:            f.kind = KIND_NONE;
        endcase
        return f;
    endfunction

    // place a field of up to eight bytes at byte position pos
    function automatic logic [XIBE_VEC_W-1:0] xibe_put(input logic [XIBE_VEC_W-1:0] v,
                                                       input logic [XIBE_CNT_W-1:0] pos,
                                                       input logic [63:0] val);
        logic [XIBE_VEC_W-1:0] ext;
        ext = XIBE_VEC_W'(val);
        return v | (ext << {pos, 3'b000});
    endfunction

endpackage

`default_nettype wire

// File: src/x86_instruction_byte_encoder.sv
// ----------------------------------------------------------------------------
// x86_instruction_byte_encoder
// Encodes one instruction request into its x86-64 machine-code bytes
// (0x66, REX, 0x0F, opcode, ModR/M, disp8/disp32, imm32/imm64, rel8), one byte
// per output transfer with tlast on the final byte.
//
//   channel  dir  tdata                                   side band
//   s_axis   in   reg,base,disp,imm,jump (112 bits)        tuser = opcode
//   m_axis   out  out_byte (8 bits)                        tlast = last
//
// An instruction is 1 to 10 bytes long; the byte serializer is the limit,
// one byte per cycle while the output is ready.
// Decode is combinational into a short queue; the next request is taken
// while earlier bytes still drain, as long as the queue has room.
// Opcodes 28..31 are accepted and produce no bytes.
// Reset is asynchronous, active low, and empties queue and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_instruction_byte_encoder
#(
    parameter int QUEUE_DEPTH = xibe_pkg::XIBE_QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // [3:0] reg_field, [7:4] base_reg, [39:8] displacement,
    // [103:40] immediate, [111:104] jump_offset
    input  wire logic [111:0] s_axis_tdata,
    // [4:0] opcode
    input  wire logic [4:0]   s_axis_tuser,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [7:0] out_byte
    output      logic [7:0]   m_axis_tdata,
    output      logic         m_axis_tlast
);
    import xibe_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_head_valid;
    xibe_item_t q_push_item;
    xibe_item_t q_head_item;

    xibe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_axis_tvalid),
        .req_ready    (s_axis_tready),
        .opcode       (s_axis_tuser),
        .reg_field    (s_axis_tdata[3:0]),
        .base_reg     (s_axis_tdata[7:4]),
        .displacement (s_axis_tdata[39:8]),
        .immediate    (s_axis_tdata[103:40]),
        .jump_offset  (s_axis_tdata[111:104]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_push_item)
    );

    xibe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    xibe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_item  (q_head_item),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: src/xibe_front.sv
// ----------------------------------------------------------------------------
// xibe_front
// Accepts a request, decodes the form and assembles the complete byte
// string with its length; pushes it into the queue in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xibe_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output      logic                 req_ready,
    input  wire logic [4:0]           opcode,
    input  wire logic [3:0]           reg_field,
    input  wire logic [3:0]           base_reg,
    input  wire logic [31:0]          displacement,
    input  wire logic [63:0]          immediate,
    input  wire logic [7:0]           jump_offset,
    input  wire logic                 q_full,
    output      logic                 q_push,
    output      xibe_pkg::xibe_item_t q_item
);
    import xibe_pkg::*;

    form_info_t             info;
    logic [3:0]             reg_eff;
    logic                   rex_w;
    logic                   rex_r;
    logic                   rex_b;
    logic                   rex_need;
    logic                   short_disp;
    logic [7:0]             op_byte;
    logic [7:0]             modrm;
    logic                   has_modrm;
    logic [63:0]            tail;
    logic [XIBE_CNT_W-1:0]  tail_len;
    logic [XIBE_VEC_W-1:0]  vec;
    logic [XIBE_CNT_W-1:0]  n;

    assign info       = xibe_decode(opcode);
    assign reg_eff    = info.fix_en ? {1'b0, info.fix_reg} : reg_field;
    assign short_disp = (displacement[31:7] == '0) || (displacement[31:7] == '1);

    always_comb
    begin
        rex_w     = 1'b0;
        rex_r     = 1'b0;
        rex_b     = 1'b0;
        rex_need  = 1'b0;
        op_byte   = info.op;
        has_modrm = 1'b0;
        modrm     = {2'b11, reg_eff[2:0], base_reg[2:0]};
        tail      = '0;
        tail_len  = '0;
        case (info.kind)
            KIND_MEM:
            begin
                rex_r     = reg_eff[3];
                rex_b     = base_reg[3];
                has_modrm = 1'b1;
                modrm     = {short_disp ? 2'b01 : 2'b10, reg_eff[2:0], base_reg[2:0]};
                tail      = 64'(displacement);
                tail_len  = short_disp ? XIBE_CNT_W'(1) : XIBE_CNT_W'(4);
            end
            KIND_RR:
            begin
                rex_r     = reg_eff[3];
                rex_b     = base_reg[3];
                has_modrm = 1'b1;
            end
            KIND_MOVI32:
            begin
                rex_b    = reg_field[3];
                op_byte  = info.op | {5'b0, reg_field[2:0]};
                tail     = {32'b0, immediate[31:0]};
                tail_len = XIBE_CNT_W'(4);
            end
            KIND_MOVI64:
            begin
                rex_w    = 1'b1;
                rex_b    = reg_field[3];
                op_byte  = info.op | {5'b0, reg_field[2:0]};
                tail     = immediate;
                tail_len = XIBE_CNT_W'(8);
            end
            KIND_JCC:
            begin
                tail     = {56'b0, jump_offset};
                tail_len = XIBE_CNT_W'(1);
            end
            default:
            begin
                tail_len = '0;
            end
        endcase
        rex_need = rex_w | rex_r | rex_b;
    end

    // prefix, REX, escape, opcode, ModR/M, then the tail field
    always_comb
    begin
        vec = '0;
        n   = '0;
        if (info.kind != KIND_NONE)
        begin
            if (info.p66)
            begin
                vec = xibe_put(vec, n, 64'h66);
                n   = n + 1'b1;
            end
            if (rex_need)
            begin
                vec = xibe_put(vec, n, {56'b0, 4'h4, rex_w, rex_r, 1'b0, rex_b});
                n   = n + 1'b1;
            end
            if (info.esc)
            begin
                vec = xibe_put(vec, n, 64'h0F);
                n   = n + 1'b1;
            end
            vec = xibe_put(vec, n, {56'b0, op_byte});
            n   = n + 1'b1;
            if (has_modrm)
            begin
                vec = xibe_put(vec, n, {56'b0, modrm});
                n   = n + 1'b1;
            end
            vec = xibe_put(vec, n, tail);
            n   = n + tail_len;
        end
    end

    // unknown forms are consumed without a queue entry
    assign req_ready    = !q_full;
    assign q_push       = req_valid && !q_full && (n != '0);
    assign q_item.bytes = vec;
    assign q_item.count = n;

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_item.count <= XIBE_CNT_W'(XIBE_MAX_BYTES)))
        else $error("front: byte count above maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (opcode <= 5'(FORM_SUB_R8_R8))) |-> q_push)
        else $error("front: known form produced no entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front: push into full queue");

endmodule

`default_nettype wire

// File: src/xibe_queue.sv
// ----------------------------------------------------------------------------
// xibe_queue
// Short register queue between the encoding front and the byte back end.
// ----------------------------------------------------------------------------
`default_nettype none

module xibe_queue
#(
    parameter int DEPTH = xibe_pkg::XIBE_QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire xibe_pkg::xibe_item_t push_item,
    output      logic                 full,
    input  wire logic                 pop,
    output      logic                 head_valid,
    output      xibe_pkg::xibe_item_t head_item
);
    import xibe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    xibe_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue: occupancy above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> (count_reg == CNT_W'(DEPTH)))
        else $error("queue: full queue changed on refused push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue: empty with pointers apart");

endmodule

`default_nettype wire

// File: src/xibe_back.sv
// ----------------------------------------------------------------------------
// xibe_back
// Serializes queued byte strings onto the output stream, one byte per
// cycle unless out_ready stalls it, through a registered output stage; marks the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xibe_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire xibe_pkg::xibe_item_t head_item,
    output      logic                 pop,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [7:0]           out_byte,
    output      logic                 out_last
);
    import xibe_pkg::*;

    logic [XIBE_VEC_W-1:0] rest_reg;
    logic [XIBE_VEC_W-1:0] rest_next;
    logic [XIBE_CNT_W-1:0] left_reg;
    logic [XIBE_CNT_W-1:0] left_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [7:0]            byte_reg;
    logic [7:0]            byte_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  slot_free;
    logic                  load;
    logic [XIBE_VEC_W-1:0] src_vec;
    logic [XIBE_CNT_W-1:0] src_cnt;

    assign slot_free = !valid_reg || out_ready;
    // bytes still held for the current instruction go before the queue head
    assign src_vec   = (left_reg != '0) ? rest_reg : head_item.bytes;
    assign src_cnt   = (left_reg != '0) ? left_reg : head_item.count;
    assign load      = slot_free && ((left_reg != '0) || head_valid);
    assign pop       = slot_free && (left_reg == '0) && head_valid;

    always_comb
    begin
        rest_next  = rest_reg;
        left_next  = left_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            byte_next  = src_vec[7:0];
            last_next  = (src_cnt == XIBE_CNT_W'(1));
            rest_next  = src_vec >> 8;
            left_next  = src_cnt - 1'b1;
            valid_next = 1'b1;
        end
        else if (slot_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != '0) |-> (valid_reg && !last_reg))
        else $error("back: bytes pending behind a last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && !last_reg) |=> valid_reg)
        else $error("back: instruction cut short");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (left_reg == '0))
        else $error("back: last byte with bytes left");

endmodule

`default_nettype wire
